@@ src/erf_pkg.sv @@
package erf_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned XW       = 15;  // clamped x, |x| <= 2.75 in Q.12
  localparam int unsigned SQW      = 23;  // x squared, unsigned Q3.20
  localparam int unsigned HW       = 32;  // Horner value, Q1.30
  localparam int unsigned OUT_W    = 16;  // result, Q1.14
  localparam int unsigned N_CELLS  = 8;
  localparam int          CLAMP_Q12 = 11264;
  localparam int          ONE_Q14   = 16384;

  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic signed [XW-1:0]  x;
    logic        [SQW-1:0] s;
    logic signed [HW-1:0]  h;
  } erf_data_t;

  function automatic logic signed [HW-1:0] coef_q30(input int unsigned k);
    logic signed [HW-1:0] c;
    case (k)
      0:       c = 32'sd1211583437;
      1:       c = -32'sd403757265;
      2:       c = 32'sd120747070;
      3:       c = -32'sd28219930;
      4:       c = 32'sd5119277;
      5:       c = -32'sd694307;
      6:       c = 32'sd65123;
      7:       c = -32'sd3696;
      default: c = 32'sd94;
    endcase
    return c;
  endfunction

endpackage

@@ src/erf_stream_if.sv @@
interface erf_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    last_in;

  modport source (output valid, output sample, output last_in, input ready);
  modport sink   (input valid, input sample, input last_in, output ready);
endinterface

interface erf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] erf_value;
  logic        last_out;

  modport source (output valid, output erf_value, output last_out, input ready);
  modport sink   (input valid, input erf_value, input last_out, output ready);
endinterface

@@ src/erf_prep.sv @@
module erf_prep
  import erf_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                    last_i,
  output erf_data_t               data_o
);

  localparam logic signed [32:0] ClampPos = 33'(CLAMP_Q12);
  localparam logic signed [32:0] ClampNeg = -33'(CLAMP_Q12);

  logic signed [32:0]    xe;
  logic signed [XW-1:0]  x_c;
  logic signed [2*XW-1:0] sq;
  logic [2*XW-1:0]       sq_r;
  erf_data_t             data_d, data_q;

  assign xe = 33'($signed(sample_i));

  always_comb begin
    if (xe > ClampPos) begin
      x_c = XW'(CLAMP_Q12);
    end else if (xe < ClampNeg) begin
      x_c = -XW'(CLAMP_Q12);
    end else begin
      x_c = xe[XW-1:0];
    end
  end

  assign sq   = x_c * x_c;
  assign sq_r = $unsigned(sq) + (2*XW)'(8);

  always_comb begin
    data_d.valid = valid_i;
    data_d.last  = last_i;
    data_d.x     = x_c;
    data_d.s     = sq_r[SQW+3:4];
    data_d.h     = coef_q30(N_CELLS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

  a_x_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_q.valid |-> (data_q.x <= XW'(CLAMP_Q12)) && (data_q.x >= -XW'(CLAMP_Q12)))
    else $error("clamped sample out of range");

  a_sq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_q.valid |-> data_q.s <= SQW'(7929856))
    else $error("square out of range");

endmodule

@@ src/erf_horner_cell.sv @@
module erf_horner_cell
  import erf_pkg::*;
#(
  parameter int unsigned COEF_IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  erf_data_t data_i,
  output erf_data_t data_o
);

  localparam logic signed [HW-1:0] Coef = coef_q30(COEF_IDX);
  localparam int unsigned PW = HW + SQW + 1;

  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic signed [XW-1:0]  x;
    logic        [SQW-1:0] s;
    logic signed [PW-1:0]  p;
  } cell_mid_t;

  cell_mid_t              mid_d, mid_q;
  logic signed [PW-1:0]   rnd;
  logic signed [PW-21:0]  t;
  logic signed [PW-20:0]  sum;
  erf_data_t              data_d, data_q;

  always_comb begin
    mid_d.valid = data_i.valid;
    mid_d.last  = data_i.last;
    mid_d.x     = data_i.x;
    mid_d.s     = data_i.s;
    mid_d.p     = data_i.h * $signed({1'b0, data_i.s});
  end

  assign rnd = mid_q.p + PW'(524288);
  assign t   = rnd[PW-1:20];
  assign sum = (PW-19)'(t) + (PW-19)'(Coef);

  always_comb begin
    data_d.valid = mid_q.valid;
    data_d.last  = mid_q.last;
    data_d.x     = mid_q.x;
    data_d.s     = mid_q.s;
    if (sum > (PW-19)'(32'sh7fffffff)) begin
      data_d.h = 32'sh7fffffff;
    end else if (sum < -(PW-19)'(33'sh080000000)) begin
      data_d.h = 32'sh80000000;
    end else begin
      data_d.h = sum[HW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= '0;
      data_q <= '0;
    end else if (en_i) begin
      mid_q  <= mid_d;
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

@@ src/erf_out_stage.sv @@
module erf_out_stage
  import erf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  erf_data_t          data_i,
  output logic               valid_o,
  output logic [OUT_W-1:0]   erf_value_o,
  output logic               last_o
);

  localparam int unsigned YW = XW + HW;

  logic                  pv_q, pl_q;
  logic signed [YW-1:0]  prod_q;
  logic signed [YW-1:0]  rnd;
  logic signed [YW-29:0] y;
  logic [OUT_W-1:0]      val_d;
  logic                  valid_q, last_q;
  logic [OUT_W-1:0]      val_q;

  assign rnd = prod_q + YW'(134217728);
  assign y   = rnd[YW-1:28];

  always_comb begin
    if (y > (YW-28)'(ONE_Q14)) begin
      val_d = OUT_W'(ONE_Q14);
    end else if (y < -(YW-28)'(ONE_Q14)) begin
      val_d = -OUT_W'(ONE_Q14);
    end else begin
      val_d = y[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= 1'b0;
      pl_q    <= 1'b0;
      prod_q  <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      val_q   <= '0;
    end else if (en_i) begin
      pv_q    <= data_i.valid;
      pl_q    <= data_i.last;
      prod_q  <= data_i.x * data_i.h;
      valid_q <= pv_q;
      last_q  <= pl_q;
      val_q   <= val_d;
    end
  end

  assign valid_o     = valid_q;
  assign erf_value_o = val_q;
  assign last_o      = last_q;

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($signed(val_q) <= 16'sd16384) && ($signed(val_q) >= -16'sd16384))
    else $error("result outside plus or minus one");

endmodule

@@ src/erf_polynomial_approx.sv @@
// Error function approximation, one sample per request.
//
// in_i  (sink):   sample (signed Q3.12 at the default width) and last_in.
// out_o (source): erf_value (signed Q1.14, within plus or minus 1.0) and
//                 last_out, a copy of last_in for the same sample.
// A request is taken on a clock edge with valid and ready both high.
//
// Each sample passes the clamp-and-square register, the eight Horner cells
// (multiply register, then round/add/saturate register), the final multiply
// register and the output register. Throughput is one sample per cycle
// unless stalled. The whole pipeline moves on one enable; while the output
// register holds an untaken result, every stage freezes and in_i.ready is
// low, so nothing is lost. Results leave in order. Reset clears all valid
// flags; the block is ready as soon as reset is released.
module erf_polynomial_approx
  import erf_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  erf_in_if.sink    in_i,
  erf_out_if.source out_o
);

  logic      en;
  erf_data_t chain [N_CELLS+1];

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  erf_prep #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .sample_i (in_i.sample),
    .last_i   (in_i.last_in),
    .data_o   (chain[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    erf_horner_cell #(
      .COEF_IDX(N_CELLS - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .data_i (chain[i]),
      .data_o (chain[i+1])
    );
  end

  erf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .data_i      (chain[N_CELLS]),
    .valid_o     (out_o.valid),
    .erf_value_o (out_o.erf_value),
    .last_o      (out_o.last_out)
  );

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while output stalled");

  a_chain_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(chain[N_CELLS]))
    else $error("pipeline moved during stall");

endmodule

@@ test/tb_erf_polynomial_approx.sv @@
module tb_erf_polynomial_approx;

  import erf_pkg::*;

  localparam int N_DIRECTED   = 24;
  localparam int N_RANDOM     = 1500;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  // Horner coefficients, Q1.30, C0 first
  localparam longint HORNER_C [9] = '{
    64'sd1211583437, -64'sd403757265, 64'sd120747070, -64'sd28219930, 64'sd5119277,
    -64'sd694307, 64'sd65123, -64'sd3696, 64'sd94
  };

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic        typed;  // erf holds a literal expectation
    logic [15:0] erf;
  } stim_row_t;

  typedef struct packed {
    logic [15:0] erf;
    logic        last;
  } erf_result_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE} rx_mode_e;

  // zero maps to zero; everything else goes through the predictor
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{16'h0000, 1'b0, 1'b1, 16'h0000},
    '{16'h0000, 1'b1, 1'b1, 16'h0000},
    '{16'h0001, 1'b0, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{16'h7FFF, 1'b0, 1'b0, 16'h0000},
    '{16'h8000, 1'b1, 1'b0, 16'h0000},
    '{16'h2C00, 1'b0, 1'b0, 16'h0000},
    '{16'hD400, 1'b1, 1'b0, 16'h0000},
    '{16'h2C01, 1'b0, 1'b0, 16'h0000},
    '{16'hD3FF, 1'b1, 1'b0, 16'h0000},
    '{16'h2BFF, 1'b0, 1'b0, 16'h0000},
    '{16'hD401, 1'b1, 1'b0, 16'h0000},
    '{16'h1000, 1'b0, 1'b0, 16'h0000},
    '{16'hF000, 1'b1, 1'b0, 16'h0000},
    '{16'h2000, 1'b0, 1'b0, 16'h0000},
    '{16'hE000, 1'b1, 1'b0, 16'h0000},
    '{16'h4000, 1'b0, 1'b0, 16'h0000},
    '{16'hC000, 1'b1, 1'b0, 16'h0000},
    '{16'h5555, 1'b0, 1'b0, 16'h0000},
    '{16'hAAAA, 1'b1, 1'b0, 16'h0000},
    '{16'h0800, 1'b0, 1'b0, 16'h0000},
    '{16'hF800, 1'b1, 1'b0, 16'h0000},
    '{16'h0064, 1'b0, 1'b0, 16'h0000},
    '{16'hFF9C, 1'b1, 1'b0, 16'h0000}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  erf_in_if #(.SAMPLE_WIDTH(16)) in_bus ();
  erf_out_if                     out_bus ();

  erf_polynomial_approx #(.SAMPLE_WIDTH(16)) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  erf_result_t erf_expected [$];
  int          mismatches = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [15:0] erf_q14_of(input logic [15:0] raw);
    longint x;
    longint sq;
    longint h;
    longint y;
    x = longint'($signed(raw));
    if (x > CLAMP_Q12) x = CLAMP_Q12;
    if (x < -CLAMP_Q12) x = -CLAMP_Q12;
    sq = (x * x + 8) >>> 4;
    h  = HORNER_C[8];
    for (int k = 7; k >= 0; k--) begin
      h = ((h * sq + (64'sd1 <<< 19)) >>> 20) + HORNER_C[k];
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
    end
    y = (x * h + (64'sd1 <<< 27)) >>> 28;
    if (y > ONE_Q14) y = ONE_Q14;
    if (y < -ONE_Q14) y = -ONE_Q14;
    return y[15:0];
  endfunction

  function automatic logic [15:0] random_sample();
    int unsigned pick;
    int          v;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      v = $urandom;
    end else if (pick < 8) begin
      v = int'($urandom_range(0, 24000)) - 12000;
    end else if (pick == 8) begin
      v = CLAMP_Q12 + int'($urandom_range(0, 8)) - 4;
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = int'($urandom_range(0, 1024)) - 512;
    end
    return v[15:0];
  endfunction

  task automatic report_mismatch(input string field, input int exp_v, input int act_v);
    if (mismatches < MAX_REPORTS)
      $display("mismatch on %s: expected %0d, got %0d", field, exp_v, act_v);
    mismatches++;
  endtask

  // Holds valid until the request is taken, then records its expectation.
  task automatic send_request(input logic [15:0] smp, input logic lst,
                              input logic typed, input logic [15:0] lit);
    erf_result_t r;
    in_bus.valid   <= 1'b1;
    in_bus.sample  <= smp;
    in_bus.last_in <= lst;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    r.erf  = typed ? lit : erf_q14_of(smp);
    r.last = lst;
    erf_expected.push_back(r);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (erf_expected.size() != 0) @(posedge clk);
  endtask

  // sender
  initial begin
    int sent;
    int burst;
    int gap;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    in_bus.last_in = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_request(DIRECTED[i].sample, DIRECTED[i].last, DIRECTED[i].typed,
                   DIRECTED[i].erf);
    wait_drained();

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
        send_request(random_sample(), 1'($urandom_range(0, 1)), 1'b0, 16'h0000);
        sent++;
      end
      if (sent % 400 < burst) begin
        wait_drained();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && erf_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (erf_expected.size() != 0)
        $display("%0d results never arrived", erf_expected.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver and checker
  initial begin
    rx_mode_e    rx_mode;
    int          rx_left;
    erf_result_t r;
    out_bus.ready = 1'b0;
    rx_mode = RX_ALWAYS;
    rx_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (erf_expected.size() == 0) begin
          report_mismatch("unexpected result, erf_value", 0, $signed(out_bus.erf_value));
        end else begin
          r = erf_expected.pop_front();
          if (out_bus.erf_value !== r.erf)
            report_mismatch("erf_value", $signed(r.erf), $signed(out_bus.erf_value));
          if (out_bus.last_out !== r.last)
            report_mismatch("last_out", r.last, out_bus.last_out);
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        RX_ALWAYS: out_bus.ready <= 1'b1;
        RX_RANDOM: out_bus.ready <= 1'($urandom_range(0, 1));
        default:   out_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #1000000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
